[hdl/assert_macros.svh]
// Assertion macros shared by the mapper RTL.
// Depends on nothing; every file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BMIRQ_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define BMIRQ_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define BMIRQ_ASSERT(lbl, clk, rstn, prop)
`define BMIRQ_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[hdl/bmirq_pkg.sv]
// Types and register codes of the bank mapper with IRQ down-counter.
// No dependencies; used by the core and the top level.
package bmirq_pkg;

	localparam int NUM_BANK_REGS = 10;
	localparam int NUM_CHR       = 8;

	localparam logic       OP_WRITE = 1'b0;
	localparam logic       OP_TICK  = 1'b1;

	localparam logic [3:0] REG_IRQ_CTRL = 4'hA;
	localparam logic [3:0] REG_LATCH_LO = 4'hB;
	localparam logic [3:0] REG_LATCH_HI = 4'hC;

	localparam logic [7:0] PRG_LAST_BANK = 8'hFF;
	localparam logic [3:0] PRG_FIX_LOW   = 4'hF;
	localparam logic [15:0] CTR_EXPIRED  = 16'hFFFF;

	typedef struct packed {
		logic       opcode;
		logic [3:0] reg_addr;
		logic [7:0] write_data;
		logic [7:0] cycles;
	} item_t;

	typedef struct packed {
		logic [NUM_CHR-1:0][7:0] chr_bank;
		logic [7:0]              prg_bank_low;
		logic [7:0]              prg_bank_high;
		logic [1:0]              mirroring;
		logic                    irq_asserted;
	} result_t;

endpackage

[hdl/bmirq_item_if.sv]
// Input channel: one bus write or cycle tick per transfer.
// Stand-alone interface; no package needed.
interface bmirq_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [3:0] reg_addr;
	logic [7:0] write_data;
	logic [7:0] cycles;

	modport source (output valid, opcode, reg_addr, write_data, cycles, input ready);
	modport sink   (input valid, opcode, reg_addr, write_data, cycles, output ready);
endinterface

[hdl/bmirq_result_if.sv]
// Output channel: bank mapping, mirroring and IRQ line per transfer.
// Stand-alone interface; no package needed.
interface bmirq_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] chr_bank_0;
	logic [7:0] chr_bank_1;
	logic [7:0] chr_bank_2;
	logic [7:0] chr_bank_3;
	logic [7:0] chr_bank_4;
	logic [7:0] chr_bank_5;
	logic [7:0] chr_bank_6;
	logic [7:0] chr_bank_7;
	logic [7:0] prg_bank_low;
	logic [7:0] prg_bank_high;
	logic [1:0] mirroring;
	logic       irq_asserted;

	modport source (output valid, chr_bank_0, chr_bank_1, chr_bank_2, chr_bank_3,
		chr_bank_4, chr_bank_5, chr_bank_6, chr_bank_7, prg_bank_low,
		prg_bank_high, mirroring, irq_asserted, input ready);
	modport sink   (input valid, chr_bank_0, chr_bank_1, chr_bank_2, chr_bank_3,
		chr_bank_4, chr_bank_5, chr_bank_6, chr_bank_7, prg_bank_low,
		prg_bank_high, mirroring, irq_asserted, output ready);
endinterface

[hdl/bmirq_core.sv]
// Mapper state: bank registers, IRQ counter and latch, and the result logic.
// Depends on bmirq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmirq_core
	import bmirq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_wdata,
	input  logic    upd,
	input  item_t   it,
	output result_t res
);

	logic [NUM_BANK_REGS-1:0][7:0] bank_q, bank_d;
	logic        irq_en_q, irq_en_d;
	logic        irq_pend_q, irq_pend_d;
	logic [15:0] ctr_q, ctr_d;
	logic [15:0] reload_q, reload_d;
	logic        bank_mode_q;
	logic [16:0] ctr_diff;
	logic [3:0]  prg_base;

	// Sign-extend the counter to 17 bits so the subtraction cannot wrap.
	assign ctr_diff = {ctr_q[15], ctr_q} - {9'd0, it.cycles};

	always_comb begin
		bank_d     = bank_q;
		irq_en_d   = irq_en_q;
		irq_pend_d = irq_pend_q;
		ctr_d      = ctr_q;
		reload_d   = reload_q;
		if (it.opcode == OP_TICK) begin
			if (irq_en_q) begin
				if (ctr_diff[16]) begin
					irq_pend_d = 1'b1;
					irq_en_d   = 1'b0;
					ctr_d      = CTR_EXPIRED;
				end else begin
					ctr_d = ctr_diff[15:0];
				end
			end
		end else begin
			for (int i = 0; i < NUM_BANK_REGS; i++) begin
				if (it.reg_addr == 4'(i))
					bank_d[i] = it.write_data;
			end
			unique case (it.reg_addr)
				REG_IRQ_CTRL: begin
					irq_pend_d = 1'b0;
					irq_en_d   = it.write_data[0];
					ctr_d      = reload_q;
				end
				REG_LATCH_LO: reload_d[7:0]  = it.write_data;
				REG_LATCH_HI: reload_d[15:8] = it.write_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= '0;
			irq_en_q    <= 1'b0;
			irq_pend_q  <= 1'b0;
			ctr_q       <= '0;
			reload_q    <= '0;
			bank_mode_q <= 1'b0;
		end else begin
			if (upd) begin
				bank_q     <= bank_d;
				irq_en_q   <= irq_en_d;
				irq_pend_q <= irq_pend_d;
				ctr_q      <= ctr_d;
				reload_q   <= reload_d;
			end
			if (cfg_we)
				bank_mode_q <= cfg_wdata;
		end
	end

	// The result reflects the state after the item has been applied.
	assign prg_base = {3'd0, bank_d[0][0]};

	always_comb begin
		if (bank_mode_q) begin
			for (int i = 0; i < NUM_CHR; i++)
				res.chr_bank[i] = 8'(i);
			res.prg_bank_low  = {prg_base, bank_d[8][3:0]};
			res.prg_bank_high = {prg_base, PRG_FIX_LOW};
		end else begin
			for (int i = 0; i < NUM_CHR; i++)
				res.chr_bank[i] = bank_d[i];
			res.prg_bank_low  = bank_d[8];
			res.prg_bank_high = PRG_LAST_BANK;
		end
		res.mirroring    = bank_d[9][1:0];
		res.irq_asserted = irq_pend_d;
	end

	`BMIRQ_NEVER(a_pend_and_en, clk, arst_n, irq_en_q && irq_pend_q)
	`BMIRQ_ASSERT(a_pend_rise, clk, arst_n, $rose(irq_pend_q) |-> $past(upd && it.opcode == OP_TICK))
	`BMIRQ_ASSERT(a_pend_fall, clk, arst_n, $fell(irq_pend_q) |-> $past(upd && it.opcode == OP_WRITE && it.reg_addr == REG_IRQ_CTRL))

endmodule

[hdl/bank_mapper_with_irq_down_counter.sv]
// Bank mapper with IRQ down-counter: each accepted item passes the input register, then the result register.
// Throughput one item per cycle unless result.ready stalls; the two registers decouple the sides.
// The state update and result logic sit between them in bmirq_core.
// Reset (arst_n low, asynchronous) clears banks, counter, latch, IRQ and bank_mode.
// Depends on bmirq_pkg, both channel interfaces and bmirq_core.
module bank_mapper_with_irq_down_counter
	import bmirq_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	bmirq_item_if.sink     item,
	bmirq_result_if.source result
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t res;
	logic    advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready)
				valid_s1 <= item.valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.opcode     <= item.opcode;
			item_s1.reg_addr   <= item.reg_addr;
			item_s1.write_data <= item.write_data;
			item_s1.cycles     <= item.cycles;
		end
		if (advance)
			out_q <= res;
	end

	bmirq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.upd       (advance),
		.it        (item_s1),
		.res       (res)
	);

	assign result.valid         = out_valid_q;
	assign result.chr_bank_0    = out_q.chr_bank[0];
	assign result.chr_bank_1    = out_q.chr_bank[1];
	assign result.chr_bank_2    = out_q.chr_bank[2];
	assign result.chr_bank_3    = out_q.chr_bank[3];
	assign result.chr_bank_4    = out_q.chr_bank[4];
	assign result.chr_bank_5    = out_q.chr_bank[5];
	assign result.chr_bank_6    = out_q.chr_bank[6];
	assign result.chr_bank_7    = out_q.chr_bank[7];
	assign result.prg_bank_low  = out_q.prg_bank_low;
	assign result.prg_bank_high = out_q.prg_bank_high;
	assign result.mirroring     = out_q.mirroring;
	assign result.irq_asserted  = out_q.irq_asserted;

endmodule
